FILE: sv/imuafp_pkg.sv
`timescale 1ns / 1ps

package imuafp_pkg;

    localparam int FRACTION_BITS = 12;
    localparam int GAIN_BITS     = 12;

    localparam int IN_W        = 8;
    localparam int ANGLE_OUT_W = 16;
    localparam int NUM_AXES    = 3;
    localparam int OUT_DATA_W  = ANGLE_OUT_W * NUM_AXES;
    localparam int AXIS_W      = 2;
    localparam int POS_W       = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int OFFSET_W   = 13;
    localparam int GAIN_W     = 14;

    localparam int RAW_W     = 16;
    localparam int PROD1_W   = 47;
    localparam int ANG_SHIFT = 44 - FRACTION_BITS;
    localparam int ANG_W     = PROD1_W - ANG_SHIFT;
    localparam int SUM_W     = ((ANG_W > OFFSET_W) ? ANG_W : OFFSET_W) + 1;
    localparam int PROD2_W   = SUM_W + GAIN_W;
    localparam int RES_W     = PROD2_W - GAIN_BITS;

    localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;

    localparam logic [IN_W-1:0] HEADER_BYTE = 8'h55;
    localparam logic [IN_W-1:0] TYPE_BYTE   = 8'h53;

    localparam logic [POS_W-1:0] POS_HUNT       = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE       = 4'd1;
    localparam logic [POS_W-1:0] POS_DATA_FIRST = 4'd2;
    localparam logic [POS_W-1:0] POS_ANGLE_LAST = 4'd7;
    localparam logic [POS_W-1:0] POS_DATA_LAST  = 4'd9;
    localparam logic [POS_W-1:0] POS_CHECK      = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_OFFSET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN     = 3'd5;

    localparam logic signed [OFFSET_W-1:0] RST_ROLL_OFFSET  = -13'sd164;
    localparam logic signed [OFFSET_W-1:0] RST_PITCH_OFFSET = 13'sd225;
    localparam logic signed [OFFSET_W-1:0] RST_YAW_OFFSET   = 13'sd0;
    localparam logic signed [GAIN_W-1:0]   RST_ROLL_GAIN    = -14'sd2662;
    localparam logic signed [GAIN_W-1:0]   RST_PITCH_GAIN   = -14'sd4096;
    localparam logic signed [GAIN_W-1:0]   RST_YAW_GAIN     = -14'sd4096;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

    typedef enum logic [3:0] {
        ST_RECV  = 4'b0001,
        ST_MUL1  = 4'b0010,
        ST_MUL2  = 4'b0100,
        ST_STORE = 4'b1000
    } t_state;

    typedef struct packed {
        logic              accept;
        logic              mul1;
        logic              mul2;
        logic              store;
        logic [AXIS_W-1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic at_check;
        logic frame_good;
    } t_status;

endpackage

FILE: sv/imuafp_ctrl.sv
`timescale 1ns / 1ps

module imuafp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  imuafp_pkg::t_status i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output imuafp_pkg::t_cmd    o_cmd
);
    import imuafp_pkg::*;

    t_state            r_state, n_state;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic              r_out_valid, n_out_valid;
    logic              w_accept;

    // checksum byte waits while the previous result is still pending
    assign o_in_ready  = (r_state == ST_RECV) && !(i_status.at_check && r_out_valid);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    assign o_cmd.accept = w_accept;
    assign o_cmd.mul1   = (r_state == ST_MUL1);
    assign o_cmd.mul2   = (r_state == ST_MUL2);
    assign o_cmd.store  = (r_state == ST_STORE);
    assign o_cmd.axis   = r_axis;

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_RECV: begin
                if (w_accept && i_status.frame_good) begin
                    n_state = ST_MUL1;
                    n_axis  = '0;
                end
            end
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_STORE;
            ST_STORE: begin
                if (r_axis == LAST_AXIS) begin
                    n_state     = ST_RECV;
                    n_out_valid = 1'b1;
                end else begin
                    n_state = ST_MUL1;
                    n_axis  = r_axis + 1'b1;
                end
            end
            default:  n_state = ST_RECV;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RECV;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    a_good_starts_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_status.frame_good) |=> (r_state == ST_MUL1) && (r_axis == '0))
        else $error("good frame did not start calculation");

    a_valid_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_STORE && r_axis == LAST_AXIS))
        else $error("result valid without finishing all axes");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis <= LAST_AXIS)
        else $error("axis counter out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STORE && r_axis == LAST_AXIS) |-> !r_out_valid)
        else $error("result overwritten while pending");

endmodule

FILE: sv/imuafp_dp.sv
`timescale 1ns / 1ps

module imuafp_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  imuafp_pkg::t_cmd                      i_cmd,
    input  logic [imuafp_pkg::IN_W-1:0]           i_byte,
    input  logic                                  i_cfg_wr_en,
    input  logic [imuafp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [imuafp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output imuafp_pkg::t_status                   o_status,
    output logic [imuafp_pkg::OUT_DATA_W-1:0]     o_result
);
    import imuafp_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [IN_W-1:0]  r_sum, n_sum;
    logic [RAW_W-1:0] r_raw [NUM_AXES];

    logic signed [OFFSET_W-1:0] r_offset [NUM_AXES];
    logic signed [GAIN_W-1:0]   r_gain   [NUM_AXES];

    logic signed [PROD1_W-1:0]     r_prod1;
    logic signed [PROD2_W-1:0]     r_prod2;
    logic [ANGLE_OUT_W-1:0]        r_result [NUM_AXES];

    logic [POS_W-1:0]        w_idx;
    logic signed [ANG_W-1:0] w_ang;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [RES_W-1:0] w_res;
    logic [ANGLE_OUT_W-1:0]  w_sat;

    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
    localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-32768);

    assign o_status.at_check   = (r_pos == POS_CHECK);
    assign o_status.frame_good = (r_pos == POS_CHECK) && (i_byte == r_sum);

    assign w_idx = r_pos - POS_DATA_FIRST;

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (r_pos == POS_TYPE) begin
            if (i_byte == TYPE_BYTE) begin
                n_sum = r_sum + i_byte;
                n_pos = POS_DATA_FIRST;
            end else if (i_byte == HEADER_BYTE) begin
                n_sum = HEADER_BYTE;
                n_pos = POS_TYPE;
            end else begin
                n_sum = '0;
                n_pos = POS_HUNT;
            end
        end else if (r_pos >= POS_DATA_FIRST && r_pos <= POS_DATA_LAST) begin
            n_sum = r_sum + i_byte;
            n_pos = r_pos + 1'b1;
        end else if (r_pos == POS_CHECK) begin
            n_sum = '0;
            n_pos = POS_HUNT;
        end else if (i_byte == HEADER_BYTE) begin
            n_sum = HEADER_BYTE;
            n_pos = POS_TYPE;
        end else begin
            n_sum = '0;
            n_pos = POS_HUNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_sum <= '0;
        end else if (i_cmd.accept) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_pos >= POS_DATA_FIRST && r_pos <= POS_ANGLE_LAST) begin
            if (w_idx[0]) begin
                r_raw[w_idx[AXIS_W:1]][15:8] <= i_byte;
            end else begin
                r_raw[w_idx[AXIS_W:1]][7:0] <= i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset[0] <= RST_ROLL_OFFSET;
            r_offset[1] <= RST_PITCH_OFFSET;
            r_offset[2] <= RST_YAW_OFFSET;
            r_gain[0]   <= RST_ROLL_GAIN;
            r_gain[1]   <= RST_PITCH_GAIN;
            r_gain[2]   <= RST_YAW_GAIN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_ROLL_OFFSET:  r_offset[0] <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_PITCH_OFFSET: r_offset[1] <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_YAW_OFFSET:   r_offset[2] <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_ROLL_GAIN:    r_gain[0]   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_PITCH_GAIN:   r_gain[1]   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_YAW_GAIN:     r_gain[2]   <= i_cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // raw * pi / 32768 in Q(FRACTION_BITS), then offset and gain
    assign w_ang = r_prod1[PROD1_W-1:ANG_SHIFT];
    assign w_sum = SUM_W'(w_ang) + SUM_W'(r_offset[i_cmd.axis]);
    assign w_res = r_prod2[PROD2_W-1:GAIN_BITS];

    always_comb begin
        if (w_res > SAT_HI) begin
            w_sat = 16'h7FFF;
        end else if (w_res < SAT_LO) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_res[ANGLE_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_prod1 <= PROD1_W'($signed(r_raw[i_cmd.axis])) * PROD1_W'(PI_Q29);
        end
        if (i_cmd.mul2) begin
            r_prod2 <= PROD2_W'(w_sum) * PROD2_W'(r_gain[i_cmd.axis]);
        end
        if (i_cmd.store) begin
            r_result[i_cmd.axis] <= w_sat;
        end
    end

    assign o_result = {r_result[2], r_result[1], r_result[0]};

endmodule

FILE: sv/imu_angle_frame_parser.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                    Payload (low bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready  rx_byte[7:0]
// m_axis    out  m_axis_tvalid/m_axis_tready  roll_angle, pitch_angle, yaw_angle
// cfg       in   i_cfg_wr_en                  index i_cfg_idx, data i_cfg_wdata
//
// One byte per cycle while a frame is received. A good checksum byte starts
// a computation (3 axes x multiply, multiply, saturate on one shared
// datapath) during which no byte is taken.
// A checksum byte is held off while the previous result is still not taken.
// Synchronous active-low reset: hunting for header, registers to defaults.

module imu_angle_frame_parser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [imuafp_pkg::IN_W-1:0]           s_axis_tdata,  // rx_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
    output logic [imuafp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                  i_cfg_wr_en,
    input  logic [imuafp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [imuafp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import imuafp_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    imuafp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    imuafp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_byte      (s_axis_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (w_status),
        .o_result    (m_axis_tdata)
    );

endmodule

FILE: verif/imu_angle_frame_parser_test.sv
`timescale 1ns / 1ps

module imu_angle_frame_parser_test;
    import imuafp_pkg::*;

    localparam longint PI_Q29_FIXED  = 1686629713;
    localparam int     ANGLE_SHIFT   = 44 - FRACTION_BITS;
    localparam int     LIMIT_CYCLES  = 200000;
    localparam int     ITEM_TARGET   = 1200;
    localparam int     NUM_PHASES    = 6;
    localparam int     SETTLE_CYCLES = 20;
    localparam int     STALL_CYCLES  = 400;
    localparam int     REPORT_MAX    = 10;
    localparam int     IDLE_PERCENT  = 9;

    typedef logic [NUM_AXES-1:0][ANGLE_OUT_W-1:0] t_angles;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    imu_angle_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // parser shadow state
    logic [POS_W-1:0]            frame_pos;
    logic [7:0]                  frame_sum;
    logic [7:0]                  angle_buf [6];
    logic signed [OFFSET_W-1:0]  axis_offset [NUM_AXES];
    logic signed [GAIN_W-1:0]    axis_gain [NUM_AXES];
    t_angles                     expected_angles [$];

    string axis_name [NUM_AXES] = '{"roll", "pitch", "yaw"};

    int  errors          = 0;
    int  results_checked = 0;
    int  bytes_sent      = 0;
    int  frames_sent     = 0;
    int  bad_frames      = 0;
    int  settings_loaded = 1;
    int  cycle_count     = 0;
    int  stall_request   = 0;
    int  stall_left      = 0;
    bit  tx_idle_en      = 1'b1;
    bit  rx_idle_en      = 1'b1;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [15:0] calibrate(input logic [7:0] lo, input logic [7:0] hi,
                                              input logic signed [OFFSET_W-1:0] offset,
                                              input logic signed [GAIN_W-1:0] gain);
        longint raw;
        longint angle;
        longint scaled;
        raw    = longint'($signed({hi, lo}));
        angle  = (raw * PI_Q29_FIXED) >>> ANGLE_SHIFT;
        scaled = ((angle + longint'(offset)) * longint'(gain)) >>> GAIN_BITS;
        if (scaled > 32767) begin
            scaled = 32767;
        end else if (scaled < -32768) begin
            scaled = -32768;
        end
        return scaled[15:0];
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, output t_angles angles);
        bit good;
        good   = 1'b0;
        angles = '0;
        if (frame_pos == POS_TYPE) begin
            if (b == TYPE_BYTE) begin
                frame_sum = frame_sum + b;
                frame_pos = POS_DATA_FIRST;
            end else if (b == HEADER_BYTE) begin
                frame_sum = HEADER_BYTE;
                frame_pos = POS_TYPE;
            end else begin
                frame_sum = '0;
                frame_pos = POS_HUNT;
            end
        end else if (frame_pos >= POS_DATA_FIRST && frame_pos <= POS_DATA_LAST) begin
            if (frame_pos <= POS_ANGLE_LAST) begin
                angle_buf[3'(frame_pos - POS_DATA_FIRST)] = b;
            end
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 1'b1;
        end else if (frame_pos == POS_CHECK) begin
            good = (b == frame_sum);
            if (good) begin
                for (int k = 0; k < NUM_AXES; k++) begin
                    angles[k] = calibrate(angle_buf[2*k], angle_buf[2*k+1],
                                          axis_offset[k], axis_gain[k]);
                end
            end
            frame_sum = '0;
            frame_pos = POS_HUNT;
        end else if (b == HEADER_BYTE) begin
            frame_sum = HEADER_BYTE;
            frame_pos = POS_TYPE;
        end else begin
            frame_sum = '0;
            frame_pos = POS_HUNT;
        end
        return good;
    endfunction

    // tracks accepted transactions and checks results against the shadow parser
    always @(posedge i_clk) begin
        t_angles got;
        t_angles want;
        if (!i_rst_n) begin
            frame_pos      = POS_HUNT;
            frame_sum      = '0;
            axis_offset[0] = RST_ROLL_OFFSET;
            axis_offset[1] = RST_PITCH_OFFSET;
            axis_offset[2] = RST_YAW_OFFSET;
            axis_gain[0]   = RST_ROLL_GAIN;
            axis_gain[1]   = RST_PITCH_GAIN;
            axis_gain[2]   = RST_YAW_GAIN;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_angles.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $display("unexpected result %h at %0t", got, $realtime);
                    end
                end else begin
                    want = expected_angles.pop_front();
                    results_checked++;
                    for (int k = 0; k < NUM_AXES; k++) begin
                        if (got[k] !== want[k]) begin
                            errors++;
                            if (errors <= REPORT_MAX) begin
                                $display("%s mismatch at %0t: expected %0d, got %0d",
                                         axis_name[k], $realtime,
                                         $signed(want[k]), $signed(got[k]));
                            end
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_byte(s_axis_tdata, want)) begin
                    expected_angles.push_back(want);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_ROLL_OFFSET:  axis_offset[0] = i_cfg_wdata[OFFSET_W-1:0];
                    CFG_PITCH_OFFSET: axis_offset[1] = i_cfg_wdata[OFFSET_W-1:0];
                    CFG_YAW_OFFSET:   axis_offset[2] = i_cfg_wdata[OFFSET_W-1:0];
                    CFG_ROLL_GAIN:    axis_gain[0]   = i_cfg_wdata[GAIN_W-1:0];
                    CFG_PITCH_GAIN:   axis_gain[1]   = i_cfg_wdata[GAIN_W-1:0];
                    CFG_YAW_GAIN:     axis_gain[2]   = i_cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // result receiver: random idling plus requested long hold-offs
    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(rx_idle_en && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (tx_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] roll_raw, input logic [15:0] pitch_raw,
                              input logic [15:0] yaw_raw, input logic [7:0] temp_lo,
                              input logic [7:0] temp_hi, input bit corrupt);
        logic [7:0] fb [11];
        logic [7:0] sum;
        fb  = '{HEADER_BYTE, TYPE_BYTE, roll_raw[7:0], roll_raw[15:8], pitch_raw[7:0],
                pitch_raw[15:8], yaw_raw[7:0], yaw_raw[15:8], temp_lo, temp_hi, 8'h00};
        sum = '0;
        for (int i = 0; i < 10; i++) begin
            sum = sum + fb[i];
        end
        fb[10] = corrupt ? 8'(sum + $urandom_range(1, 255)) : sum;
        foreach (fb[i]) begin
            send_byte(fb[i]);
        end
        frames_sent++;
        if (corrupt) begin
            bad_frames++;
        end
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (expected_angles.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic load_registers(input int roll_off, input int pitch_off, input int yaw_off,
                                  input int roll_g, input int pitch_g, input int yaw_g);
        write_reg(CFG_ROLL_OFFSET, CFG_DATA_W'(roll_off));
        write_reg(CFG_PITCH_OFFSET, CFG_DATA_W'(pitch_off));
        write_reg(CFG_YAW_OFFSET, CFG_DATA_W'(yaw_off));
        write_reg(CFG_ROLL_GAIN, CFG_DATA_W'(roll_g));
        write_reg(CFG_PITCH_GAIN, CFG_DATA_W'(pitch_g));
        write_reg(CFG_YAW_GAIN, CFG_DATA_W'(yaw_g));
        // unmapped index, must be ignored
        write_reg(CFG_IDX_W'(CFG_YAW_GAIN + 1 + $urandom_range(1)), CFG_DATA_W'($urandom));
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        settings_loaded++;
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_unit();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 70) begin
            send_frame(pick_raw(), pick_raw(), pick_raw(), 8'($urandom), 8'($urandom), 1'b0);
        end else if (kind < 82) begin
            send_frame(pick_raw(), pick_raw(), pick_raw(), 8'($urandom), 8'($urandom), 1'b1);
        end else if (kind < 88) begin
            send_byte(HEADER_BYTE);
            send_byte($urandom_range(1) ? HEADER_BYTE : 8'($urandom));
        end else if (kind < 94) begin
            // frame cut short; the next bytes get swallowed as its payload
            n = $urandom_range(7);
            send_byte(HEADER_BYTE);
            send_byte(TYPE_BYTE);
            repeat (n) send_byte(8'($urandom));
        end else begin
            send_byte(8'($urandom));
        end
    endtask

    // resync on noise, repeated header, wrong type and bad checksum, at reset settings
    task automatic test_frame_sync();
        send_byte(8'hFF);
        send_byte(HEADER_BYTE);
        send_frame(16'h7FFF, 16'h8000, 16'hFFFF, 8'hFF, 8'h00, 1'b0);
        send_byte(HEADER_BYTE);
        send_byte(8'h00);
        send_frame(16'h0000, 16'h0001, 16'h8001, 8'h00, 8'hFF, 1'b1);
        wait_quiet();
    endtask

    task automatic test_random_traffic();
        int phase_end;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_quiet();
            case (phase)
                0: load_registers(4095, 4095, 4095, 8191, 8191, 8191);
                1: load_registers(-4096, -4096, -4096, -8192, -8192, -8192);
                2: load_registers(4095, -4096, 0, -8192, 8191, 0);
                3: load_registers(0, 0, 0, 4096, 4096, 4096);
                default: load_registers($urandom_range(16383), $urandom_range(16383),
                                        $urandom_range(16383), $urandom_range(16383),
                                        $urandom_range(16383), $urandom_range(16383));
            endcase
            tx_idle_en = (phase != 3);
            rx_idle_en = (phase != 3);
            phase_end  = bytes_sent + ITEM_TARGET / NUM_PHASES;
            while (bytes_sent < phase_end) begin
                send_random_unit();
            end
        end
        wait_quiet();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // receiver blocks for a long time while good frames keep coming
    task automatic test_output_stall();
        tx_idle_en    = 1'b0;
        stall_request = STALL_CYCLES;
        repeat (5) begin
            send_frame(pick_raw(), pick_raw(), pick_raw(), 8'($urandom), 8'($urandom), 1'b0);
        end
        wait_quiet();
        tx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frame_sync();
        test_random_traffic();
        test_output_stall();

        if (expected_angles.size() != 0) begin
            errors += expected_angles.size();
            $display("%0d expected results never arrived", expected_angles.size());
        end
        $display("Sent %0d bytes in %0d frames (%0d with a corrupt checksum) plus noise;",
                 bytes_sent, frames_sent, bad_frames);
        $display("checked %0d results over %0d register settings, %0d errors.",
                 results_checked, settings_loaded, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
